[rtl/int_to_decimal_ascii_core_assert.svh]
// assertion macros shared by the conversion core modules
`ifndef INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define ITDA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itda assertion failed");

// next-cycle implication, held off during reset
`define ITDA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itda assertion failed");

`endif

[rtl/itda_pkg.sv]
package itda_pkg;

	// field widths
	localparam int NUM_W  = 32;
	localparam int MAG_W  = 32;
	localparam int CHAR_W = 7;
	localparam int LEN_W  = 4;
	localparam int POS_W  = 4;
	// wide enough for nine times the largest place value
	localparam int MULT_W = 34;

	localparam int MAX_DIGITS = 10;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

	// classified number travelling from front to back
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [POS_W-1:0] ndig;
	} job_t;

	// place value of a decimal position
	function automatic logic [MULT_W-1:0] pow10(input logic [POS_W-1:0] pos);
		logic [MULT_W-1:0] r;
		case (pos)
			4'd0:    r = 34'd1;
			4'd1:    r = 34'd10;
			4'd2:    r = 34'd100;
			4'd3:    r = 34'd1000;
			4'd4:    r = 34'd10000;
			4'd5:    r = 34'd100000;
			4'd6:    r = 34'd1000000;
			4'd7:    r = 34'd10000000;
			4'd8:    r = 34'd100000000;
			4'd9:    r = 34'd1000000000;
			default: r = 34'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/itda_front.sv]
module itda_front import itda_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [NUM_W-1:0] number,
	output logic                    q_wr,
	output job_t                    q_job,
	input  logic                    q_full
);

	logic             valid_s1;
	logic             neg_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [NUM_W-1:0] raw;
	logic             take;
	logic [POS_W-1:0] ndig;

	// input transaction handshake
	assign take = push && !full;
	assign full = valid_s1 && q_full;
	assign q_wr = valid_s1 && !q_full;
	assign raw  = number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	// sign and magnitude, the most negative value wraps to 2^31 unsigned
	always_ff @(posedge clk) begin
		if (take) begin
			neg_s1 <= raw[NUM_W-1];
			mag_s1 <= raw[NUM_W-1] ? (~raw + 32'd1) : raw;
		end
	end

	// digit count from parallel place value compares
	always_comb begin
		logic [MULT_W-1:0] place;
		ndig = 4'd1;
		for (int k = 1; k < MAX_DIGITS; k++) begin
			place = pow10(POS_W'(k));
			if (mag_s1 >= place[MAG_W-1:0]) begin
				ndig = ndig + 4'd1;
			end
		end
	end

	assign q_job = '{neg: neg_s1, mag: mag_s1, ndig: ndig};

endmodule

[rtl/itda_queue.sv]
`include "int_to_decimal_ascii_core_assert.svh"

module itda_queue import itda_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	output logic full,
	input  logic rd,
	output job_t rd_job,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (wr) begin
			entries_q[wr_ptr_q] <= wr_job;
		end
	end

	`ITDA_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`ITDA_ASSERT_IMPL(a_no_overrun, clk, arst_n, full && !rd, !wr)

endmodule

[rtl/itda_back.sv]
`include "int_to_decimal_ascii_core_assert.svh"

module itda_back import itda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  job_t              q_job,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output logic [CHAR_W-1:0] text_char,
	output logic              last_char,
	output logic [LEN_W-1:0]  text_length
);

	logic              busy_q;
	logic              sign_q;
	logic [MAG_W-1:0]  rem_q;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [LEN_W-1:0]  olen_q;

	logic              out_free;
	logic              advance;
	logic              is_last;
	logic              load;
	logic [3:0]        digit;
	logic [MAG_W-1:0]  sub;
	logic [MAG_W-1:0]  rem_next;
	logic [CHAR_W-1:0] next_char;

	// emit one character whenever a number is being converted and the output register can take it
	assign out_free = !out_valid_q || pop;
	assign advance  = busy_q && out_free;
	assign is_last  = !sign_q && (pos_q == '0);
	assign load     = !q_empty && (!busy_q || (advance && is_last));
	assign q_rd     = load;

	// current digit by compare against all multiples of the place value
	always_comb begin
		logic [MULT_W-1:0] cand;
		digit = 4'd0;
		sub   = '0;
		for (int d = 1; d < 10; d++) begin
			cand = pow10(pos_q) * MULT_W'(d);
			if ({2'b00, rem_q} >= cand) begin
				digit = 4'(d);
				sub   = cand[MAG_W-1:0];
			end
		end
	end

	assign rem_next  = rem_q - sub;
	assign next_char = sign_q ? CHAR_MINUS : (CHAR_ZERO + {3'b000, digit});

	// conversion sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				sign_q <= q_job.neg;
			end else if (advance && is_last) begin
				busy_q <= 1'b0;
			end else if (advance && sign_q) begin
				sign_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// remainder, position and character payload
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= q_job.mag;
			pos_q <= q_job.ndig - 4'd1;
			len_q <= q_job.ndig + {3'b000, q_job.neg};
		end else if (advance && !sign_q) begin
			rem_q <= rem_next;
			pos_q <= pos_q - 4'd1;
		end
		if (advance) begin
			char_q <= next_char;
			last_q <= is_last;
			olen_q <= len_q;
		end
	end

	assign empty       = !out_valid_q;
	assign text_char   = char_q;
	assign last_char   = last_q;
	assign text_length = olen_q;

	`ITDA_ASSERT_IMPL(a_ndig_range, clk, arst_n, load, (q_job.ndig >= 4'd1) && (q_job.ndig <= 4'd10))
	`ITDA_ASSERT_IMPL(a_rem_fits, clk, arst_n, busy_q && !sign_q, {2'b00, rem_q} < pow10(pos_q) * 34'd10)
	`ITDA_ASSERT_IMPL(a_last_clears, clk, arst_n, advance && is_last, rem_next == '0)
	`ITDA_ASSERT_NEXT(a_load_busy, clk, arst_n, load, busy_q && (len_q != '0))

endmodule

[rtl/int_to_decimal_ascii_core.sv]
// Converts one signed 32-bit number per input transaction into its decimal
// ASCII text, most significant character first, one character per output
// transaction, with a leading '-' for negative values; every character carries
// the total text length and the final one is flagged by last_char. A number
// passes through an input register, where its sign and magnitude are formed
// and its digit count is classified, and then a short queue (QUEUE_DEPTH
// entries, at least 2) into the converter. The converter produces one
// character per cycle whenever the character output register can take it,
// by comparing the remainder against the multiples of the current place
// value, so a number of 1 to 11 characters occupies the converter until its
// last character enters the character output register, and that register
// sets the sustained rate. New numbers are taken while earlier ones are still
// being converted until the queue and the input register are both full.
module int_to_decimal_ascii_core import itda_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [NUM_W-1:0] number,
	input  logic                    pop,
	output logic                    empty,
	output logic [CHAR_W-1:0]       text_char,
	output logic                    last_char,
	output logic [LEN_W-1:0]        text_length
);

	logic q_wr;
	logic q_full;
	logic q_rd;
	logic q_empty;
	job_t wr_job;
	job_t rd_job;

	// sign, magnitude and digit count
	itda_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.number (number),
		.q_wr   (q_wr),
		.q_job  (wr_job),
		.q_full (q_full)
	);

	// decoupling queue between classification and conversion
	itda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_job (wr_job),
		.full   (q_full),
		.rd     (q_rd),
		.rd_job (rd_job),
		.empty  (q_empty)
	);

	// digit generation and character output
	itda_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (rd_job),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.text_char   (text_char),
		.last_char   (last_char),
		.text_length (text_length)
	);

endmodule

[tb/itda_text_check.sv]
// watches both channels, spells out every accepted number and compares the characters
module itda_text_check import itda_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic signed [NUM_W-1:0] number,
	input  logic                    pop,
	input  logic                    empty,
	input  logic [CHAR_W-1:0]       text_char,
	input  logic                    last_char,
	input  logic [LEN_W-1:0]        text_length,
	output int                      fail_count,
	output int                      chars_pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic [LEN_W-1:0]  len;
	} text_char_t;

	// characters still owed by the block, oldest first
	text_char_t expected_text[$];

	// decimal text of one number, sign first, appended to the expected characters
	function automatic void spell_number(input logic [NUM_W-1:0] value);
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [3:0]       digit [0:MAX_DIGITS-1];
		int               nd;
		int               total;
		int               k;
		text_char_t       c;
		neg = value[NUM_W-1];
		// magnitude in unsigned arithmetic, so the most negative value needs no care
		mag = neg ? (MAG_W'(0) - value) : value;
		nd = 0;
		do begin
			digit[nd] = 4'(mag % 10);
			mag = mag / 10;
			nd++;
		end while (mag != 0 && nd < MAX_DIGITS);
		total = nd + (neg ? 1 : 0);
		if (neg) begin
			c.ch   = CHAR_MINUS;
			c.last = 1'b0;
			c.len  = LEN_W'(total);
			expected_text.push_back(c);
		end
		for (k = nd - 1; k >= 0; k--) begin
			c.ch   = CHAR_ZERO + CHAR_W'(digit[k]);
			c.last = (k == 0);
			c.len  = LEN_W'(total);
			expected_text.push_back(c);
		end
	endfunction

	// compare each output transaction, then predict from each input transaction
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		int         errs;
		if (!arst_n) begin
			expected_text.delete();
			fail_count    <= 0;
			chars_pending <= 0;
		end else begin
			errs = 0;
			if (pop && !empty) begin
				if (expected_text.size() == 0) begin
					$display("%0t: character %0d arrived with nothing expected",
						$time, text_char);
					errs++;
				end else begin
					want = expected_text.pop_front();
					if (text_char !== want.ch) begin
						$display("%0t: text_char expected %0d actual %0d",
							$time, want.ch, text_char);
						errs++;
					end
					if (last_char !== want.last) begin
						$display("%0t: last_char expected %0d actual %0d",
							$time, want.last, last_char);
						errs++;
					end
					if (text_length !== want.len) begin
						$display("%0t: text_length expected %0d actual %0d",
							$time, want.len, text_length);
						errs++;
					end
				end
			end
			if (push && !full)
				spell_number(number);
			if (errs != 0)
				fail_count <= fail_count + errs;
			chars_pending <= expected_text.size();
		end
	end

endmodule

[tb/tb_int_to_decimal_ascii_core.sv]
module tb_int_to_decimal_ascii_core;
	import itda_pkg::*;

	localparam int ITEM_COUNT   = 260;
	localparam int DIRECTED_N   = 22;
	// receiver hold-off window, long enough to fill the queue and stall input
	localparam int STALL_START  = 450;
	localparam int STALL_CYCLES = 300;
	// stretches with no idling on either side
	localparam int STEADY_START = 1600;
	localparam int STEADY_END   = 2300;
	localparam int BURST_FIRST  = 120;
	localparam int BURST_LAST   = 170;
	localparam int DRAIN_CYCLES = 40;
	// worst case is far below this: 11 characters per number, each behind the longest random receiver stall
	localparam int CYCLE_LIMIT  = 400000;

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic signed [NUM_W-1:0] number;
	logic                    pop;
	logic                    empty;
	logic [CHAR_W-1:0]       text_char;
	logic                    last_char;
	logic [LEN_W-1:0]        text_length;
	int                      fail_count;
	int                      chars_pending;
	int                      cycle_count;

	int_to_decimal_ascii_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.number      (number),
		.pop         (pop),
		.empty       (empty),
		.text_char   (text_char),
		.last_char   (last_char),
		.text_length (text_length)
	);

	itda_text_check text_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.number        (number),
		.pop           (pop),
		.empty         (empty),
		.text_char     (text_char),
		.last_char     (last_char),
		.text_length   (text_length),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// directed numbers: zero, single digits, digit count edges, both extremes
	function automatic logic [NUM_W-1:0] directed_number(input int idx);
		case (idx)
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'hffff_ffff;
			3:       return 32'h8000_0000;
			4:       return 32'h7fff_ffff;
			5:       return 32'h8000_0001;
			6:       return 32'd9;
			7:       return 32'd10;
			8:       return -32'sd10;
			9:       return 32'd99;
			10:      return 32'd100;
			11:      return -32'sd9;
			12:      return 32'd999_999_999;
			13:      return 32'd1_000_000_000;
			14:      return -32'sd999_999_999;
			15:      return -32'sd1_000_000_000;
			16:      return 32'h5555_5555;
			17:      return 32'haaaa_aaaa;
			18:      return 32'd123_456_789;
			19:      return -32'sd123_456_789;
			20:      return 32'd2_000_000_000;
			default: return 32'd0;
		endcase
	endfunction

	// random number: full range, extremes, or a chosen digit count with random sign
	function automatic logic [NUM_W-1:0] draw_number();
		logic [63:0]      span;
		logic [63:0]      wide;
		logic [NUM_W-1:0] mag;
		int               nd;
		int               k;
		case ($urandom_range(0, 5))
			0, 1: return $urandom();
			2: begin
				case ($urandom_range(0, 3))
					0:       return 32'h8000_0000;
					1:       return 32'h7fff_ffff;
					2:       return 32'd0;
					default: return 32'hffff_ffff;
				endcase
			end
			default: begin
				nd = $urandom_range(1, MAX_DIGITS);
				span = 64'd1;
				for (k = 0; k < nd; k++)
					span = span * 10;
				wide = {32'($urandom()), 32'($urandom())} % span;
				mag = wide[NUM_W-1:0];
				return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
			end
		endcase
	endfunction

	// sender idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// reset and sender
	initial begin
		int               idx;
		int               gap;
		logic [NUM_W-1:0] value;
		arst_n = 1'b0;
		push   = 1'b0;
		number = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (idx = 0; idx < ITEM_COUNT; idx++) begin
			value = (idx < DIRECTED_N) ? directed_number(idx) : draw_number();
			push   <= 1'b1;
			number <= value;
			do @(posedge clk); while (full);
			gap = (idx >= BURST_FIRST && idx <= BURST_LAST) ? 0 : pick_gap();
			if (gap > 0) begin
				push   <= 1'b0;
				number <= $urandom();
				repeat (gap) @(posedge clk);
			end
		end
		push <= 1'b0;
		// wait for every owed character, then let the pipeline settle
		do @(posedge clk); while (chars_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("int_to_decimal_ascii_core: match");
		else
			$display("int_to_decimal_ascii_core: mismatch");
		$finish;
	end

	// receiver: random stalls, one long hold-off and one stretch popping every cycle
	initial begin
		int hold_left;
		int rcv_cycle;
		int r;
		pop = 1'b0;
		hold_left = 0;
		rcv_cycle = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			rcv_cycle++;
			if (rcv_cycle >= STALL_START && rcv_cycle < STALL_START + STALL_CYCLES) begin
				pop <= 1'b0;
			end else if (rcv_cycle >= STEADY_START && rcv_cycle < STEADY_END) begin
				pop <= 1'b1;
			end else if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					hold_left = $urandom_range(10, 40);
				else if (r < 20)
					hold_left = $urandom_range(0, 2);
				pop <= (r >= 20);
			end
		end
	end

	// timeout
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("int_to_decimal_ascii_core: mismatch");
		$finish;
	end

endmodule
